>>> rtl/laq_pkg.sv
package laq_pkg;

	// build defaults and fixed field geometry
	localparam int NumPhasesDef  = 3;
	localparam int NumClassesDef = 6;
	localparam int DelayWidthDef = 10;
	localparam int MaxPhases     = 3;
	localparam int MaxClasses    = 6;
	localparam int DelayFieldW   = 10;

	localparam int VoltW   = 20;
	localparam int CurrW   = 20;
	localparam int PowW    = 32;
	localparam int DiW     = 4;
	localparam int DoW     = 2;
	localparam int FlagW   = 18;
	localparam int SumW    = 8;
	localparam int IoW     = 6;
	localparam int KeepPolW = 18;
	localparam int DelayPackW = 60;

	// configuration port geometry and register indexes
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 60;

	localparam logic [CfgIdxW-1:0] RegVolOver  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegVolUnder = 3'd1;
	localparam logic [CfgIdxW-1:0] RegCurOver  = 3'd2;
	localparam logic [CfgIdxW-1:0] RegCurUnder = 3'd3;
	localparam logic [CfgIdxW-1:0] RegPowOver  = 3'd4;
	localparam logic [CfgIdxW-1:0] RegPowUnder = 3'd5;
	localparam logic [CfgIdxW-1:0] RegDelay    = 3'd6;
	localparam logic [CfgIdxW-1:0] RegKeepPol  = 3'd7;

	// register reset values
	localparam logic [VoltW-1:0]       VolOverRst  = 20'd26400;
	localparam logic [VoltW-1:0]       VolUnderRst = 20'd17600;
	localparam logic [CurrW-1:0]       CurOverRst  = 20'd100000;
	localparam logic [CurrW-1:0]       CurUnderRst = 20'd0;
	localparam logic [PowW-1:0]        PowOverRst  = 32'h7FFF_FFFF;
	localparam logic [PowW-1:0]        PowUnderRst = 32'h8000_0000;
	localparam logic [DelayPackW-1:0]  DelayRst    = 60'd0;
	localparam logic [KeepPolW-1:0]    KeepPolRst  = 18'd245760;

	typedef struct packed {
		logic [VoltW-1:0]       volt_a;
		logic [VoltW-1:0]       volt_b;
		logic [VoltW-1:0]       volt_c;
		logic [CurrW-1:0]       curr_a;
		logic [CurrW-1:0]       curr_b;
		logic [CurrW-1:0]       curr_c;
		logic signed [PowW-1:0] pow_a;
		logic signed [PowW-1:0] pow_b;
		logic signed [PowW-1:0] pow_c;
		logic [DiW-1:0]         di_pins;
		logic [DoW-1:0]         do_pins;
	} sample_t;

	typedef struct packed {
		logic [FlagW-1:0] raw_limit_flags;
		logic [SumW-1:0]  summary_alarms;
		logic [IoW-1:0]   io_alarms;
		logic [DiW-1:0]   di_active;
	} result_t;

	// per-class control from the compare logic to a qualifier
	typedef struct packed {
		logic step;  // a sample is being retired this cycle
		logic flag;  // any phase of the class violates its limit
		logic keep;  // latch the alarm once set
	} cls_ctl_t;

endpackage

>>> rtl/limit_alarm_qualifier_core.sv
// Limit alarm qualifier.
// Sample channel (smp_valid / smp_stall / sample): one request per tick unless stalled,
// carrying three-phase voltage, current and power plus the DI and DO pin levels.
// Result channel (res_valid / res_stall / result): exactly one result per sample,
// in order: raw compare flags, qualified summary alarms, per-pin alarms and the
// polarity-corrected DI levels.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; write only while no sample is in flight.
// A sample is held in the sample register, then its result is written to the result
// register behind res_valid; unless stalled, throughput is one sample per cycle,
// set by the single compare-and-qualify stage that sits between the sample
// register and the result register.
// When the receiver stalls, a two-entry result buffer (result register plus skid)
// absorbs results; smp_stall rises once the skid entry and the sample register
// are both occupied, and drops again as soon as results drain.
// Reset clears all counters and alarm state and restores the register defaults.
module limit_alarm_qualifier_core #(
	parameter int NUM_PHASES  = laq_pkg::NumPhasesDef,
	parameter int NUM_CLASSES = laq_pkg::NumClassesDef,
	parameter int DELAY_WIDTH = laq_pkg::DelayWidthDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          smp_valid,
	output logic                          smp_stall,
	input  laq_pkg::sample_t              sample,
	output logic                          res_valid,
	input  logic                          res_stall,
	output laq_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [laq_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [laq_pkg::CfgDataW-1:0]  cfg_data
);
	import laq_pkg::*;

	logic [VoltW-1:0]      vol_over_q;
	logic [VoltW-1:0]      vol_under_q;
	logic [CurrW-1:0]      cur_over_q;
	logic [CurrW-1:0]      cur_under_q;
	logic [PowW-1:0]       pow_over_q;
	logic [PowW-1:0]       pow_under_q;
	logic [DelayPackW-1:0] delay_q;
	logic [KeepPolW-1:0]   keep_pol_q;

	sample_t               smp_s1;
	logic                  vld_s1;
	logic                  adv;

	logic [FlagW-1:0]      flags;
	logic [MaxClasses-1:0] cls_alarm_d;
	logic [DiW-1:0]        di_act;
	logic [IoW-1:0]        io_q;
	logic [IoW-1:0]        io_d;
	logic [1:0]            pin_sum_q;
	logic [1:0]            pin_sum_d;
	logic [SumW-1:0]       skeep;
	logic [IoW-1:0]        iokeep;
	logic [DiW-1:0]        pol;
	result_t               res_d;

	result_t               res_q;
	logic                  res_vld_q;
	result_t               skid_q;
	logic                  skid_vld_q;
	logic                  pop;

	logic [VoltW-1:0]       volt [MaxPhases];
	logic [CurrW-1:0]       curr [MaxPhases];
	logic signed [PowW-1:0] powv [MaxPhases];

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_over_q  <= VolOverRst;
			vol_under_q <= VolUnderRst;
			cur_over_q  <= CurOverRst;
			cur_under_q <= CurUnderRst;
			pow_over_q  <= PowOverRst;
			pow_under_q <= PowUnderRst;
			delay_q     <= DelayRst;
			keep_pol_q  <= KeepPolRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegVolOver:  vol_over_q  <= cfg_data[VoltW-1:0];
				RegVolUnder: vol_under_q <= cfg_data[VoltW-1:0];
				RegCurOver:  cur_over_q  <= cfg_data[CurrW-1:0];
				RegCurUnder: cur_under_q <= cfg_data[CurrW-1:0];
				RegPowOver:  pow_over_q  <= cfg_data[PowW-1:0];
				RegPowUnder: pow_under_q <= cfg_data[PowW-1:0];
				RegDelay:    delay_q     <= cfg_data[DelayPackW-1:0];
				RegKeepPol:  keep_pol_q  <= cfg_data[KeepPolW-1:0];
				default: ;
			endcase
		end
	end

	// sample register
	assign smp_stall = vld_s1 && skid_vld_q;
	assign adv       = vld_s1 && !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!smp_stall) begin
			vld_s1 <= smp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (smp_valid && !smp_stall) begin
			smp_s1 <= sample;
		end
	end

	// per-phase views of the sample
	assign volt[0] = smp_s1.volt_a;
	assign volt[1] = smp_s1.volt_b;
	assign volt[2] = smp_s1.volt_c;
	assign curr[0] = smp_s1.curr_a;
	assign curr[1] = smp_s1.curr_b;
	assign curr[2] = smp_s1.curr_c;
	assign powv[0] = smp_s1.pow_a;
	assign powv[1] = smp_s1.pow_b;
	assign powv[2] = smp_s1.pow_c;

	// limit compares, bit 3*class+phase
	always_comb begin
		logic [MaxClasses-1:0] cmp;
		flags = '0;
		cmp   = '0;
		for (int p = 0; p < MaxPhases; p++) begin
			if (p < NUM_PHASES) begin
				cmp[0] = volt[p] > vol_over_q;
				cmp[1] = volt[p] < vol_under_q;
				cmp[2] = curr[p] > cur_over_q;
				cmp[3] = curr[p] < cur_under_q;
				cmp[4] = powv[p] > $signed(pow_over_q);
				cmp[5] = powv[p] < $signed(pow_under_q);
				for (int k = 0; k < MaxClasses; k++) begin
					if (k < NUM_CLASSES) begin
						flags[3*k+p] = cmp[k];
					end
				end
			end
		end
	end

	// class qualifiers
	for (genvar k = 0; k < MaxClasses; k++) begin : g_cls
		if (k < NUM_CLASSES) begin : g_on
			cls_ctl_t ctl;
			assign ctl.step = adv;
			assign ctl.flag = |flags[3*k +: 3];
			assign ctl.keep = skeep[k];
			laq_class_qual #(
				.DELAY_WIDTH (DELAY_WIDTH)
			) u_qual (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.delay   (delay_q[DelayFieldW*k +: DelayFieldW]),
				.alarm_d (cls_alarm_d[k])
			);
		end else begin : g_off
			assign cls_alarm_d[k] = 1'b0;
		end
	end

	// digital pin alarms with keep latching
	assign skeep  = keep_pol_q[7:0];
	assign iokeep = keep_pol_q[13:8];
	assign pol    = keep_pol_q[17:14];
	assign di_act = ~(smp_s1.di_pins ^ pol);

	assign io_d = {smp_s1.do_pins, di_act} | (iokeep & io_q);
	assign pin_sum_d[0] = (|di_act) | (skeep[6] & pin_sum_q[0]);
	assign pin_sum_d[1] = (|smp_s1.do_pins) | (skeep[7] & pin_sum_q[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			io_q      <= '0;
			pin_sum_q <= '0;
		end else if (adv) begin
			io_q      <= io_d;
			pin_sum_q <= pin_sum_d;
		end
	end

	always_comb begin
		res_d.raw_limit_flags = flags;
		res_d.summary_alarms  = {pin_sum_d, cls_alarm_d};
		res_d.io_alarms       = io_d;
		res_d.di_active       = di_act;
	end

	// result register with skid entry
	assign pop = res_vld_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (adv) begin
			if (res_vld_q && !pop) begin
				skid_vld_q <= 1'b1;
			end
			res_vld_q <= 1'b1;
		end else if (pop) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				res_q <= skid_q;
			end
		end else if (adv) begin
			if (res_vld_q && !pop) begin
				skid_q <= res_d;
			end else begin
				res_q <= res_d;
			end
		end
	end

	assign res_valid = res_vld_q;
	assign result    = res_q;

endmodule

>>> rtl/laq_class_qual.sv
module laq_class_qual #(
	parameter int DELAY_WIDTH = laq_pkg::DelayWidthDef
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  laq_pkg::cls_ctl_t                ctl,
	input  logic [laq_pkg::DelayFieldW-1:0]  delay,
	output logic                             alarm_d
);
	import laq_pkg::*;

	localparam int DlyExtW = (DELAY_WIDTH > DelayFieldW) ? DELAY_WIDTH : DelayFieldW;
	localparam logic [DELAY_WIDTH-1:0] CntMax = {DELAY_WIDTH{1'b1}};
	localparam logic [DlyExtW-1:0] CntMaxExt = DlyExtW'(CntMax);

	logic [DELAY_WIDTH-1:0] cnt_q;
	logic [DELAY_WIDTH-1:0] cnt_d;
	logic                   alarm_q;
	logic [DlyExtW-1:0]     dly_ext;
	logic [DELAY_WIDTH-1:0] dly;

	// delay field clipped to what the counter can reach
	assign dly_ext = DlyExtW'(delay);
	assign dly     = (dly_ext > CntMaxExt) ? CntMax : dly_ext[DELAY_WIDTH-1:0];

	// integrating counter: up while flagged, down while clear
	always_comb begin
		cnt_d   = cnt_q;
		alarm_d = alarm_q;
		if (ctl.flag) begin
			if (cnt_q >= dly) begin
				alarm_d = 1'b1;
				cnt_d   = dly;
			end else begin
				cnt_d = cnt_q + 1'b1;
			end
		end else if (cnt_q == '0) begin
			if (!ctl.keep) begin
				alarm_d = 1'b0;
			end
		end else begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			alarm_q <= 1'b0;
		end else if (ctl.step) begin
			cnt_q   <= cnt_d;
			alarm_q <= alarm_d;
		end
	end

endmodule
